// File: rtl/rpl_pkg.sv
// Shared types, constants and the entry merge function for the read pair layout merge.
`default_nettype none
package rpl_pkg;

   localparam int MaxReadLen = 512;

   localparam int BaseW  = 8;
   localparam int OpW    = 8;
   localparam int AgrW   = 8;
   localparam int QualW  = 16;
   localparam int FlagW  = 2;
   localparam int PosW   = 31;
   localparam int FuncW  = 2;
   localparam int EntryW = BaseW + OpW + AgrW + QualW + FlagW;

   // starts are signed; offsets, totals and the read-out counter span the
   // whole reference range plus one read
   localparam int StartW = 33;
   localparam int IdxW   = 33;

   localparam int ReqDataW = 80;
   localparam int RspDataW = 48;

   localparam logic [OpW-1:0]   OP_M      = 8'd77;
   localparam logic [OpW-1:0]   OP_S      = 8'd83;
   localparam logic [BaseW-1:0] BASE_N    = 8'd78;
   localparam logic [FlagW-1:0] FLAG_AGREE = 2'd2;
   localparam logic [FlagW-1:0] FLAG_NONE  = 2'd0;

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD_FIRST  = 2'd0,
      FUNC_LOAD_SECOND = 2'd1,
      FUNC_READ_OUT    = 2'd2,
      FUNC_UNUSED      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_TOTAL,
      ST_INDEX,
      ST_FETCH,
      ST_MERGE
   } state_type;

   typedef enum logic [1:0] {
      SRC_LEAD,
      SRC_MERGE,
      SRC_TRAIL,
      SRC_GAP
   } src_type;

   typedef struct packed {
      logic [BaseW-1:0] base;
      logic [OpW-1:0]   op;
      logic [AgrW-1:0]  agr;
      logic [QualW-1:0] qual;
      logic [FlagW-1:0] flag;
   } entry_type;

   typedef struct packed {
      logic    load;
      src_type src;
      logic    lead_first;
      logic    last;
   } merge_ctl_type;

   function automatic entry_type merge_pair(entry_type a, entry_type b);
      entry_type        r;
      logic [AgrW:0]    agr_sum;
      logic [QualW:0]   qual_sum;
      r        = a;
      agr_sum  = {1'b0, a.agr} + {1'b0, b.agr};
      qual_sum = {1'b0, a.qual} + {1'b0, b.qual};
      if (a.base == b.base) begin
         if (a.op == b.op || b.op == OP_S) begin
            r.agr  = agr_sum[AgrW] ? {AgrW{1'b1}} : agr_sum[AgrW-1:0];
            r.qual = qual_sum[QualW] ? {QualW{1'b1}} : qual_sum[QualW-1:0];
            r.flag = FLAG_AGREE;
         end else if (b.base != BASE_N) begin
            r.base = BASE_N;
            r.agr  = '0;
            r.flag = FLAG_NONE;
         end
      end else if (a.op == b.op) begin
         if (a.qual >= b.qual) begin
            r.qual = a.qual - b.qual;
         end else begin
            r.base = b.base;
            r.qual = b.qual - a.qual;
         end
         r.flag = FLAG_NONE;
      end else begin
         r.agr  = '0;
         r.qual = '0;
         r.flag = FLAG_NONE;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/read_pair_layout_merge.sv
// Top level of the read pair layout merge: layout stores, start tracking and read-out sequencer.
//
//  channel | dir | handshake              | word
//  req     | in  | req_tvalid/req_tready  | tuser=func, tdata=entry fields and ref_pos
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata=merged entry, tlast=final entry
//
//  A load writes one entry into the store of its read.
//  A read-out steps through start compare, total, index clamp, store read and merge before its
//  word enters the result register; the next word is taken in the cycle after that, and an
//  empty layout frees the input after the index clamp.
//  Reset clears lengths, starts and the read-out counter; stores are not cleared.
//  A full result register stalls the read-out in its merge step; the input waits meanwhile.
`default_nettype none
module read_pair_layout_merge #(
   parameter int MAX_READ_LEN = rpl_pkg::MaxReadLen
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [7:0] base, [15:8] operation, [23:16] agreement, [39:24] quality,
   // [41:40] merge_flag, [72:42] ref_pos, rest zero
   input  wire logic [rpl_pkg::ReqDataW-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [rpl_pkg::FuncW-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] out_base, [15:8] out_operation, [23:16] out_agreement,
   // [39:24] out_quality, [41:40] out_merge_flag, rest zero
   output logic [rpl_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                               rsp_tlast
);
   import rpl_pkg::*;

   localparam int AddrW = $clog2(MAX_READ_LEN);
   localparam int LenW  = $clog2(MAX_READ_LEN + 1);

   state_type state_ff, state_in;

   logic [LenW-1:0]          first_len_ff, first_len_in;
   logic [LenW-1:0]          second_len_ff, second_len_in;
   logic signed [StartW-1:0] first_start_ff, first_start_in;
   logic signed [StartW-1:0] second_start_ff, second_start_in;
   logic                     first_found_ff, first_found_in;
   logic                     second_found_ff, second_found_in;
   logic [IdxW-1:0]          idx_ff, idx_in;

   logic            lead_first_ff, lead_first_in;
   logic [IdxW-1:0] offset_ff, offset_in;
   logic [LenW-1:0] lead_len_ff, lead_len_in;
   logic [LenW-1:0] trail_len_ff, trail_len_in;
   logic [IdxW-1:0] total_ff, total_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic            last_ff, last_in;
   src_type         src_ff, src_in;

   logic                     req_acc;
   func_type                 func;
   entry_type                req_entry;
   logic [PosW-1:0]          req_pos;
   logic                     load_first;
   logic                     load_second;
   logic signed [StartW-1:0] pos_ext;

   logic            idx_over;
   logic [IdxW-1:0] idx_inc;
   logic [IdxW-1:0] trail_idx;
   logic [AddrW-1:0] lead_addr;
   logic [AddrW-1:0] trail_addr;

   logic             ram_re;
   logic [AddrW-1:0] first_raddr;
   logic [AddrW-1:0] second_raddr;
   entry_type        first_rdata;
   entry_type        second_rdata;
   logic             out_free;
   merge_ctl_type    mctl;

   assign req_acc   = req_tvalid && req_tready;
   assign func      = func_type'(req_tuser);
   assign req_entry = '{base: req_tdata[7:0], op: req_tdata[15:8], agr: req_tdata[23:16],
                        qual: req_tdata[39:24], flag: req_tdata[41:40]};
   assign req_pos   = req_tdata[72:42];
   assign pos_ext   = $signed({{(StartW - PosW){1'b0}}, req_pos});

   assign load_first  = req_acc && func == FUNC_LOAD_FIRST
                        && first_len_ff < LenW'(MAX_READ_LEN);
   assign load_second = req_acc && func == FUNC_LOAD_SECOND
                        && second_len_ff < LenW'(MAX_READ_LEN);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && func == FUNC_READ_OUT) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:  state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_INDEX;
         ST_INDEX: begin
            // empty layout: no word
            state_in = (total_ff == '0) ? ST_IDLE : ST_FETCH;
         end
         ST_FETCH: state_in = ST_MERGE;
         ST_MERGE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready      = 1'b0;
      ram_re          = 1'b0;
      mctl.load       = 1'b0;
      mctl.src        = src_ff;
      mctl.lead_first = lead_first_ff;
      mctl.last       = last_ff;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_FETCH: ram_re = 1'b1;
         ST_MERGE: mctl.load = out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // store fill, start tracking and read-out counter
   always_comb begin
      first_len_in    = first_len_ff;
      second_len_in   = second_len_ff;
      first_start_in  = first_start_ff;
      second_start_in = second_start_ff;
      first_found_in  = first_found_ff;
      second_found_in = second_found_ff;
      idx_in          = idx_ff;
      idx_over        = idx_ff >= total_ff;
      idx_inc         = idx_ff + IdxW'(1);
      last_in         = last_ff;
      pos_in          = pos_ff;

      if (load_first) begin
         first_len_in = first_len_ff + LenW'(1);
         if (!first_found_ff && req_entry.op == OP_M) begin
            first_found_in = 1'b1;
            first_start_in = pos_ext - $signed({{(StartW - LenW){1'b0}}, first_len_ff});
         end
      end
      if (load_second) begin
         second_len_in = second_len_ff + LenW'(1);
         if (!second_found_ff && req_entry.op == OP_M) begin
            second_found_in = 1'b1;
            second_start_in = pos_ext - $signed({{(StartW - LenW){1'b0}}, second_len_ff});
         end
      end

      if (state_ff == ST_INDEX && total_ff != '0) begin
         // clamp to the final entry when the layout shrank below the counter
         pos_in  = idx_over ? total_ff - IdxW'(1) : idx_ff;
         last_in = idx_over || idx_inc == total_ff;
         if (last_in) begin
            first_len_in    = '0;
            second_len_in   = '0;
            first_start_in  = '1;
            second_start_in = '1;
            first_found_in  = 1'b0;
            second_found_in = 1'b0;
            idx_in          = '0;
         end else begin
            idx_in = idx_inc;
         end
      end
   end

   // lead selection, offset and total
   always_comb begin
      lead_first_in = lead_first_ff;
      offset_in     = offset_ff;
      lead_len_in   = lead_len_ff;
      trail_len_in  = trail_len_ff;
      total_in      = total_ff;
      if (state_ff == ST_CALC) begin
         lead_first_in = !(first_start_ff > second_start_ff);
         offset_in     = lead_first_in ? IdxW'(second_start_ff - first_start_ff)
                                       : IdxW'(first_start_ff - second_start_ff);
         lead_len_in   = lead_first_in ? first_len_ff : second_len_ff;
         trail_len_in  = lead_first_in ? second_len_ff : first_len_ff;
      end
      if (state_ff == ST_TOTAL) begin
         total_in = offset_ff + IdxW'(trail_len_ff);
      end
   end

   // store addresses and entry source
   always_comb begin
      trail_idx    = pos_ff - offset_ff;
      lead_addr    = pos_ff[AddrW-1:0];
      trail_addr   = trail_idx[AddrW-1:0];
      first_raddr  = lead_first_ff ? lead_addr : trail_addr;
      second_raddr = lead_first_ff ? trail_addr : lead_addr;
      src_in       = src_ff;
      if (state_ff == ST_FETCH) begin
         if (pos_ff < offset_ff) begin
            src_in = (pos_ff < IdxW'(lead_len_ff)) ? SRC_LEAD : SRC_GAP;
         end else begin
            src_in = (pos_ff < IdxW'(lead_len_ff)) ? SRC_MERGE : SRC_TRAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_len_ff    <= '0;
         second_len_ff   <= '0;
         first_start_ff  <= '1;
         second_start_ff <= '1;
         first_found_ff  <= 1'b0;
         second_found_ff <= 1'b0;
         idx_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         first_len_ff    <= first_len_in;
         second_len_ff   <= second_len_in;
         first_start_ff  <= first_start_in;
         second_start_ff <= second_start_in;
         first_found_ff  <= first_found_in;
         second_found_ff <= second_found_in;
         idx_ff          <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_first_ff <= lead_first_in;
      offset_ff     <= offset_in;
      lead_len_ff   <= lead_len_in;
      trail_len_ff  <= trail_len_in;
      total_ff      <= total_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      src_ff        <= src_in;
   end

   rpl_ram #(
      .Width (EntryW),
      .Depth (MAX_READ_LEN)
   ) u_first_store (
      .clock (clock),
      .we    (load_first),
      .waddr (first_len_ff[AddrW-1:0]),
      .wdata (req_entry),
      .re    (ram_re),
      .raddr (first_raddr),
      .rdata (first_rdata)
   );

   rpl_ram #(
      .Width (EntryW),
      .Depth (MAX_READ_LEN)
   ) u_second_store (
      .clock (clock),
      .we    (load_second),
      .waddr (second_len_ff[AddrW-1:0]),
      .wdata (req_entry),
      .re    (ram_re),
      .raddr (second_raddr),
      .rdata (second_rdata)
   );

   rpl_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mctl),
      .first_rdata  (first_rdata),
      .second_rdata (second_rdata),
      .out_free     (out_free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: rtl/rpl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rpl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/rpl_merge.sv
// Entry merge and result register: picks lead, trail, merged or gap entry and holds the word.
`default_nettype none
module rpl_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rpl_pkg::merge_ctl_type    ctl,
   input  wire rpl_pkg::entry_type        first_rdata,
   input  wire rpl_pkg::entry_type        second_rdata,
   output logic                           out_free,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [rpl_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                           rsp_tlast
);
   import rpl_pkg::*;

   entry_type lead_entry;
   entry_type trail_entry;
   entry_type result;
   entry_type data_ff;
   entry_type data_in;
   logic      valid_ff;
   logic      valid_in;
   logic      last_ff;
   logic      last_in;

   always_comb begin
      lead_entry  = ctl.lead_first ? first_rdata : second_rdata;
      trail_entry = ctl.lead_first ? second_rdata : first_rdata;
      case (ctl.src)
         SRC_LEAD:  result = lead_entry;
         SRC_MERGE: result = merge_pair(lead_entry, trail_entry);
         SRC_TRAIL: result = trail_entry;
         SRC_GAP:   result = '{base: BASE_N, op: '0, agr: '0, qual: '0, flag: '0};
         default:   result = lead_entry;
      endcase
   end

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      data_in  = data_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (ctl.load) begin
         data_in  = result;
         last_in  = ctl.last;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(RspDataW - EntryW){1'b0}},
                        data_ff.flag, data_ff.qual, data_ff.agr, data_ff.op, data_ff.base};

endmodule
`default_nettype wire

// File: rtl/rpl_checker.sv
// Port-level assertions for the read pair layout merge, bound to the top level.
`default_nettype none
module rpl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [rpl_pkg::ReqDataW-1:0]  req_tdata,
   input wire logic [rpl_pkg::FuncW-1:0]     req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [rpl_pkg::RspDataW-1:0]  rsp_tdata,
   input wire logic                          rsp_tlast
);
   import rpl_pkg::*;

   logic req_acc;
   logic readout_acc;

   assign req_acc     = req_tvalid && req_tready;
   assign readout_acc = req_acc && req_tuser == FUNC_READ_OUT && req_tdata[0] == req_tdata[0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_readout_busy: assert property (@(posedge clock) disable iff (reset)
      readout_acc |=> !req_tready)
      else $error("read-out did not occupy the sequencer");

   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser != FUNC_READ_OUT |=> req_tready)
      else $error("load blocked the next word");

   a_result_from_readout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a read-out in progress");

endmodule

bind read_pair_layout_merge rpl_checker u_rpl_checker (.*);
`default_nettype wire
